### rtl/ucwp_pkg.sv
// Package for the serial command window parser.
// Holds sizes, character codes, beat types and the speed field decoder.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ucwp_pkg;

   localparam int WINDOW_BYTES = 16;
   localparam int ADDR_W       = $clog2(WINDOW_BYTES);
   localparam int STEP_W       = $clog2(WINDOW_BYTES + 2);
   localparam int MAX_RESULTS  = 9;
   localparam int CNT_W        = $clog2(MAX_RESULTS);

   localparam logic [7:0] CHR_B     = 8'h42;
   localparam logic [7:0] CHR_X     = 8'h58;
   localparam logic [7:0] CHR_Y     = 8'h59;
   localparam logic [7:0] CHR_MINUS = 8'h2D;
   localparam logic [7:0] CHR_0     = 8'h30;
   localparam logic [7:0] CHR_1     = 8'h31;
   localparam logic [7:0] CHR_6     = 8'h36;
   localparam logic [7:0] CHR_9     = 8'h39;

   localparam logic OP_PUSH    = 1'b0;
   localparam logic OP_PROCESS = 1'b1;

   localparam logic EVT_BUTTON   = 1'b0;
   localparam logic EVT_JOYSTICK = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic              event_kind;
      logic [2:0]        button_number;
      logic signed [7:0] x_speed_out;
      logic signed [7:0] y_speed_out;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic              hit;
      logic signed [7:0] value;
   } speed_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CHR_0) && (b <= CHR_9);
   endfunction

   // Decode the up to three bytes that follow a speed marker.
   function automatic speed_type parse_speed(input logic [7:0] b1,
                                             input logic [7:0] b2,
                                             input logic [7:0] b3);
      speed_type  r;
      logic [7:0] d1;
      logic [7:0] d2;
      logic [7:0] d3;
      d1      = b1 - CHR_0;
      d2      = b2 - CHR_0;
      d3      = b3 - CHR_0;
      r.hit   = 1'b0;
      r.value = '0;
      if (b1 == CHR_MINUS) begin
         if (is_digit(b2)) begin
            r.hit = 1'b1;
            if (is_digit(b3)) begin
               r.value = 8'd0 - ((d2 << 3) + (d2 << 1) + d3);
            end else begin
               r.value = 8'd0 - d2;
            end
         end
      end else if (is_digit(b1)) begin
         r.hit = 1'b1;
         if (is_digit(b2)) begin
            r.value = (d1 << 3) + (d1 << 1) + d2;
         end else begin
            r.value = d1;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/uart_command_window_parser.sv
// Serial command window parser: top level.
// Holds the window memory, the scan sequencer and the result register.
// Depends on ucwp_pkg.
//
// Usage: the req channel carries push beats (one received byte, shifted
// into a sliding window of WINDOW_BYTES bytes) and process beats. A push
// gives no result. A process beat with no byte pushed since the last scan
// gives no result. Otherwise the block walks the window once, one memory
// position per cycle while the walk does not pause, then passes through the
// finish and drain states; req_stall is high from the process beat until
// the block is back in idle, including any time the receiver stalls it.
// Button events appear on rsp during the walk (the last one after it), a
// joystick event after it; the final beat of a process beat carries last.
// req_stall stays high while a scan runs.
// The window sits in a circular memory with one read and one write port;
// the single read port sets the scan length.
// Reset clears the window (by per-entry valid bits), speeds and mark at
// once. When rsp_stall is high the result register holds and one more event
// waits in a pending register; the walk pauses only when an event finds both
// full, and the finish and drain states wait for the result register to free.
`timescale 1ns / 1ps
`default_nettype none

module uart_command_window_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ucwp_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ucwp_pkg::rsp_type     rsp_data
);

   import ucwp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_DRAIN
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [ADDR_W-1:0] phys_ff, phys_in;
   logic [ADDR_W-1:0] prev_ff, prev_in;
   logic [7:0]        b1_ff, b1_in, b2_ff, b2_in, b3_ff, b3_in;
   logic signed [7:0] xs_ff, xs_in, ys_ff, ys_in;
   logic signed [7:0] xnow_ff, xnow_in, ynow_ff, ynow_in;
   logic              mark_ff, mark_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   rsp_type           pend_ff, pend_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // window memory
   logic [7:0]              window_mem_ff [WINDOW_BYTES];
   logic [WINDOW_BYTES-1:0] valid_ff;
   logic [7:0]              rd_data_ff;
   logic                    rd_valid_ff;
   logic                    mem_we, mem_re, valid_set;
   logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
   logic [7:0]              mem_wdata;

   logic       accept, out_free, step_go, btn_ev, b1_live, joy;
   logic [7:0] cur_byte;
   speed_type  spd;
   rsp_type    joy_evt;

   function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] a);
      return (a == ADDR_W'(WINDOW_BYTES - 1)) ? '0 : a + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (mem_we) begin
         window_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff  <= window_mem_ff[mem_raddr];
         rd_valid_ff <= valid_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (valid_set) begin
         valid_ff[mem_waddr] <= 1'b1;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // a never-written entry reads as zero; positions past the end too
   assign cur_byte = (step_ff < STEP_W'(WINDOW_BYTES) && rd_valid_ff) ? rd_data_ff : 8'h00;
   assign b1_live  = (step_ff != '0) && (step_ff <= STEP_W'(WINDOW_BYTES - 1));
   assign btn_ev   = (state_ff == ST_SCAN) && b1_live && (b1_ff == CHR_B)
                     && (cur_byte >= CHR_1) && (cur_byte <= CHR_6)
                     && (cnt_ff < CNT_W'(MAX_RESULTS - 1));
   assign step_go  = !(btn_ev && pend_valid_ff && !out_free);
   assign spd      = parse_speed(b2_ff, b1_ff, cur_byte);
   assign joy      = (xs_ff != xnow_ff) || (ys_ff != ynow_ff);

   always_comb begin
      joy_evt.event_kind    = EVT_JOYSTICK;
      joy_evt.button_number = '0;
      joy_evt.x_speed_out   = xs_ff;
      joy_evt.y_speed_out   = ys_ff;
      joy_evt.last          = 1'b0;
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      head_in       = head_ff;
      phys_in       = phys_ff;
      prev_in       = prev_ff;
      b1_in         = b1_ff;
      b2_in         = b2_ff;
      b3_in         = b3_ff;
      xs_in         = xs_ff;
      ys_in         = ys_ff;
      xnow_in       = xnow_ff;
      ynow_in       = ynow_ff;
      mark_in       = mark_ff;
      cnt_in        = cnt_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      valid_set     = 1'b0;
      mem_waddr     = head_ff;
      mem_raddr     = head_ff;
      mem_wdata     = req_data.rx_byte;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.operation == OP_PUSH) begin
                  // overwrite the oldest byte, it becomes the newest
                  mem_we    = 1'b1;
                  valid_set = 1'b1;
                  head_in   = next_addr(head_ff);
                  mark_in   = 1'b1;
               end else if (mark_ff) begin
                  mem_re   = 1'b1;
                  phys_in  = head_ff;
                  step_in  = '0;
                  b1_in    = '0;
                  b2_in    = '0;
                  b3_in    = '0;
                  xs_in    = xnow_ff;
                  ys_in    = ynow_ff;
                  cnt_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (step_go) begin
               b1_in   = cur_byte;
               b2_in   = b1_ff;
               b3_in   = b2_ff;
               prev_in = phys_ff;
               phys_in = next_addr(phys_ff);
               step_in = step_ff + 1'b1;
               if (step_ff < STEP_W'(WINDOW_BYTES - 1)) begin
                  mem_re    = 1'b1;
                  mem_raddr = next_addr(phys_ff);
               end
               // clear markers behind the read position
               if (b1_live && (b1_ff == CHR_B || b1_ff == CHR_X || b1_ff == CHR_Y)) begin
                  mem_we    = 1'b1;
                  mem_waddr = prev_ff;
                  mem_wdata = 8'h00;
               end
               if (btn_ev) begin
                  cnt_in = cnt_ff + 1'b1;
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = pend_ff;
                  end
                  pend_in.event_kind    = EVT_BUTTON;
                  pend_in.button_number = cur_byte[2:0];
                  pend_in.x_speed_out   = '0;
                  pend_in.y_speed_out   = '0;
                  pend_in.last          = 1'b0;
                  pend_valid_in         = 1'b1;
               end
               if (spd.hit && b3_ff == CHR_X) begin
                  xs_in = spd.value;
               end
               if (spd.hit && b3_ff == CHR_Y) begin
                  ys_in = spd.value;
               end
               if (step_ff == STEP_W'(WINDOW_BYTES + 1)) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (!joy) begin
               state_in = ST_DRAIN;
            end else if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = pend_ff;
               end
               pend_in       = joy_evt;
               pend_valid_in = 1'b1;
               xnow_in       = '0;
               ynow_in       = '0;
               state_in      = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pend_valid_ff) begin
               mark_in  = 1'b0;
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_data_in      = pend_ff;
               rsp_data_in.last = 1'b1;
               pend_valid_in    = 1'b0;
               mark_in          = 1'b0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         mark_ff       <= 1'b0;
         xnow_ff       <= '0;
         ynow_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         mark_ff       <= mark_in;
         xnow_ff       <= xnow_in;
         ynow_ff       <= ynow_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      step_ff     <= step_in;
      phys_ff     <= phys_in;
      prev_ff     <= prev_in;
      b1_ff       <= b1_in;
      b2_ff       <= b2_in;
      b3_ff       <= b3_in;
      xs_ff       <= xs_in;
      ys_ff       <= ys_in;
      cnt_ff      <= cnt_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      (xnow_ff >= -8'sd99) && (xnow_ff <= 8'sd99) && (ynow_ff >= -8'sd99) && (ynow_ff <= 8'sd99))
      else $error("stored speed out of range");

   a_button_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.event_kind == EVT_BUTTON) |->
      ((rsp_data_ff.button_number >= 3'd1) && (rsp_data_ff.button_number <= 3'd6)))
      else $error("button beat with bad button number");

   a_joystick_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.event_kind == EVT_JOYSTICK) |-> rsp_data_ff.last)
      else $error("joystick beat not marked last");

   a_mark_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && state_in == ST_IDLE) |=> !mark_ff)
      else $error("updated mark survived a scan");
`endif

endmodule

`default_nettype wire

### bench/tb_top.sv
// Testbench for uart_command_window_parser: random and directed byte streams with scan beats.
// A built-in window model predicts button and joystick events; a monitor checks every result.
// Depends on ucwp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_top;
   import ucwp_pkg::*;

   localparam int HOLD_CYCLES    = 200;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS    = 57;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Stimulus and scoreboard state
   req_type    pending_beats[$];
   rsp_type    expected_events[$];
   int         items_queued   = 0;
   int         error_count    = 0;
   int         send_idle_pct  = 0;
   int         recv_stall_pct = 0;
   logic       hold_request   = 1'b0;
   int         hold_count     = 0;
   int         stuck_cycles   = 0;

   // Window model
   logic [7:0] win [WINDOW_BYTES];
   logic       win_mark = 1'b0;
   int         x_speed  = 0;
   int         y_speed  = 0;

   uart_command_window_parser uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   initial begin
      for (int i = 0; i < WINDOW_BYTES; i++) begin
         win[i] = '0;
      end
   end

   // ---------------------------------------------------------------- model

   // Positions past the end read as zero, which is never a digit.
   function automatic logic [7:0] win_at(int pos);
      if (pos >= WINDOW_BYTES) begin
         return 8'h00;
      end
      return win[pos];
   endfunction

   function automatic logic is_numeral(logic [7:0] b);
      return (b >= CHR_0) && (b <= CHR_9);
   endfunction

   function automatic int numeral_val(logic [7:0] b);
      return int'(b) - int'(CHR_0);
   endfunction

   function automatic int speed_from(int pos, int current);
      int speed;
      speed = current;
      if (win_at(pos + 1) == CHR_MINUS) begin
         if (is_numeral(win_at(pos + 2))) begin
            speed = -numeral_val(win_at(pos + 2));
            if (is_numeral(win_at(pos + 3))) begin
               speed = -(numeral_val(win_at(pos + 2)) * 10 + numeral_val(win_at(pos + 3)));
            end
         end
      end else if (is_numeral(win_at(pos + 1))) begin
         speed = numeral_val(win_at(pos + 1));
         if (is_numeral(win_at(pos + 2))) begin
            speed = numeral_val(win_at(pos + 1)) * 10 + numeral_val(win_at(pos + 2));
         end
      end
      return speed;
   endfunction

   function automatic void predict_events(req_type beat);
      rsp_type    found[$];
      rsp_type    ev;
      int         i;
      int         x_prev;
      int         y_prev;
      logic [7:0] nb;
      if (beat.operation == OP_PUSH) begin
         for (i = 0; i < WINDOW_BYTES - 1; i++) begin
            win[i] = win[i + 1];
         end
         win[WINDOW_BYTES - 1] = beat.rx_byte;
         win_mark = 1'b1;
         return;
      end
      if (!win_mark) begin
         return;
      end
      for (i = 0; i < WINDOW_BYTES - 1; i++) begin
         if (win[i] == CHR_B) begin
            nb = win[i + 1];
            win[i] = 8'h00;
            if (nb >= CHR_1 && nb <= CHR_6 && found.size() < MAX_RESULTS - 1) begin
               ev = '0;
               ev.event_kind = EVT_BUTTON;
               ev.button_number = 3'(nb - CHR_0);
               found.push_back(ev);
            end
         end
      end
      x_prev = x_speed;
      y_prev = y_speed;
      for (i = 0; i < WINDOW_BYTES - 1; i++) begin
         if (win[i] == CHR_X) begin
            win[i] = 8'h00;
            x_speed = speed_from(i, x_speed);
         end
         if (win[i] == CHR_Y) begin
            win[i] = 8'h00;
            y_speed = speed_from(i, y_speed);
         end
      end
      if (x_speed != x_prev || y_speed != y_prev) begin
         ev = '0;
         ev.event_kind = EVT_JOYSTICK;
         ev.x_speed_out = 8'(x_speed);
         ev.y_speed_out = 8'(y_speed);
         found.push_back(ev);
         x_speed = 0;
         y_speed = 0;
      end
      win_mark = 1'b0;
      if (found.size() > 0) begin
         found[found.size() - 1].last = 1'b1;
      end
      foreach (found[k]) begin
         expected_events.push_back(found[k]);
      end
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_events(req_data);
         end
         if (!req_valid || !req_stall) begin
            if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_beats.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_request && hold_count < HOLD_CYCLES) begin
         // hold off long enough for results to back up into the input
         rsp_stall  <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            $display("%0t: unexpected event: kind=%0d button=%0d x=%0d y=%0d last=%0d",
                     $time, rsp_data.event_kind, rsp_data.button_number,
                     rsp_data.x_speed_out, rsp_data.y_speed_out, rsp_data.last);
            error_count <= error_count + 1;
         end else begin
            want = expected_events.pop_front();
            if (want.event_kind != rsp_data.event_kind ||
                want.button_number != rsp_data.button_number ||
                want.x_speed_out != rsp_data.x_speed_out ||
                want.y_speed_out != rsp_data.y_speed_out ||
                want.last != rsp_data.last) begin
               $display("%0t: event mismatch: expected kind=%0d button=%0d x=%0d y=%0d last=%0d",
                        $time, want.event_kind, want.button_number,
                        want.x_speed_out, want.y_speed_out, want.last);
               $display("%0t:                 actual   kind=%0d button=%0d x=%0d y=%0d last=%0d",
                        $time, rsp_data.event_kind, rsp_data.button_number,
                        rsp_data.x_speed_out, rsp_data.y_speed_out, rsp_data.last);
               error_count <= error_count + 1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic add_push(logic [7:0] b);
      req_type beat;
      beat.operation = OP_PUSH;
      beat.rx_byte   = b;
      pending_beats.push_back(beat);
      items_queued++;
   endtask

   task automatic add_process();
      req_type beat;
      beat.operation = OP_PROCESS;
      beat.rx_byte   = 8'($urandom_range(0, 255));
      pending_beats.push_back(beat);
      items_queued++;
   endtask

   task automatic add_string(string s);
      for (int i = 0; i < s.len(); i++) begin
         add_push(s[i]);
      end
   endtask

   // One command frame: one to three tokens, mostly well formed, then usually a scan (sometimes none, sometimes two).
   task automatic add_frame();
      int tokens;
      int t;
      int digits;
      tokens = $urandom_range(1, 3);
      for (t = 0; t < tokens; t++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               add_push(CHR_B);
               if ($urandom_range(0, 7) != 0) begin
                  add_push(8'(CHR_1 + $urandom_range(0, 5)));
               end else begin
                  add_push(8'($urandom_range(0, 255)));
               end
            end
            4, 5, 6: begin
               add_push($urandom_range(0, 1) ? CHR_X : CHR_Y);
               if ($urandom_range(0, 2) == 0) begin
                  add_push(CHR_MINUS);
               end
               digits = $urandom_range(0, 4);
               if (digits > 2) begin
                  digits = 2;
               end
               repeat (digits) add_push(8'(CHR_0 + $urandom_range(0, 9)));
            end
            7, 8: begin
               case ($urandom_range(0, 4))
                  0: add_push(CHR_B);
                  1: add_push(CHR_X);
                  2: add_push(CHR_Y);
                  3: add_push(CHR_MINUS);
                  default: add_push(8'(CHR_0 + $urandom_range(0, 9)));
               endcase
            end
            default: add_push(8'($urandom_range(0, 255)));
         endcase
      end
      if ($urandom_range(0, 9) != 0) begin
         add_process();
      end
      if ($urandom_range(0, 9) == 0) begin
         add_process();
      end
   endtask

   task automatic fill_frames(int n);
      int start;
      start = items_queued;
      while (items_queued - start < n) begin
         add_frame();
      end
   endtask

   // Wait for all beats to go in and every event to come out, then let the block settle.
   task automatic drain();
      while (pending_beats.size() != 0 || req_valid) begin
         @(negedge clock);
      end
      while (expected_events.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, int n);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      fill_frames(n);
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: scan with nothing pushed, one of each event, edge bytes,
      // 'B' in the last slot, unchanged speed, and a repeated scan
      add_process();
      add_string("B6");
      add_process();
      add_string("X-99");
      add_process();
      add_string("Y99B1");
      add_process();
      add_push(8'hFF);
      add_push(8'h00);
      add_process();
      add_push(CHR_B);
      add_process();
      add_push(8'h33);
      add_process();
      add_string("X0");
      add_process();
      add_process();
      drain();

      run_phase(0, 0, PHASE_ITEMS);
      run_phase(84, 0, PHASE_ITEMS);
      run_phase(0, 84, PHASE_ITEMS);
      run_phase(12, 12, PHASE_ITEMS);

      // long receiver hold-off while the sender keeps offering
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 1'b1;
      fill_frames(PHASE_ITEMS);
      while (hold_count < HOLD_CYCLES) begin
         @(negedge clock);
      end
      hold_request = 1'b0;
      drain();

      if (error_count == 0 && expected_events.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/ucwp_pkg.sv
rtl/uart_command_window_parser.sv
bench/tb_top.sv
